[src/rafw_pkg.sv]
// Shared constants and field widths for the region allocator.
package rafw_pkg;

  localparam int MODE_W   = 2;
  localparam int REQ_W    = 20;
  localparam int ADDR_W   = 20;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int BLK_W    = 17;

  localparam logic [MODE_W-1:0] MODE_ALLOC     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE_ADDR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE_POS  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRATEGY   = 2'd2;

  localparam logic [REQ_W-1:0] TOTAL_RESET = 20'd65536;
  localparam logic [BLK_W-1:0] BLOCK_RESET = 17'd16;

endpackage

[src/rafw_if.sv]
// Channel interfaces: request, response and configuration write.
interface rafw_in_if import rafw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [REQ_W-1:0]    req_size;
  logic [ADDR_W-1:0]   address;
  logic [POS_W-1:0]    position;
  modport source (output valid, mode, req_size, address, position, input ready);
  modport sink   (input valid, mode, req_size, address, position, output ready);
endinterface

interface rafw_out_if import rafw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   region_start;
  logic [TOTAL_W-1:0]  region_total;
  modport source (output valid, status, region_start, region_total, input ready);
  modport sink   (input valid, status, region_start, region_total, output ready);
endinterface

interface rafw_cfg_if import rafw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/rafw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rafw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/region_allocator_first_worst_fit_unit.sv]
// Region allocator top level: first/worst fit placement with coalescing on free.
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+---------------------------------------------
//  cfg     | in  | valid/ready   | index, data (register write)
//  cmd     | in  | valid/ready   | mode, req_size, address, position
//  rsp     | out | valid/ready   | status, region_start, region_total
//
// One word is processed at a time. An allocate first computes the rounding
// remainder, then scans the table, and for a split opens a slot by moving
// the entries above the pick up by one. A free scans the table and then runs
// a merge pass over every entry, testing each free/free pair against the
// granule remainder in the bit-serial unit.
// Reset and a write to any of the three defined registers rebuild the table
// from entry zero.
// The response sits in an output register; a stalled rsp holds the next word
// in its final state until the register frees.
module region_allocator_first_worst_fit_unit import rafw_pkg::*; #(
  parameter int MAX_REGIONS = 64,
  parameter int ADDR_BITS   = 20
) (
  input  logic      clk,
  input  logic      rst,
  rafw_cfg_if.sink  cfg,
  rafw_in_if.sink   cmd,
  rafw_out_if.source rsp
);

  localparam int AB   = ADDR_BITS;
  localparam int IW   = $clog2(MAX_REGIONS);
  localparam int CW   = $clog2(MAX_REGIONS + 1);
  localparam int NW   = 21;                       // rounded request width
  localparam int CMPW = (AB > NW) ? AB : NW;
  localparam int XW   = (AB > ADDR_W) ? AB : ADDR_W;
  localparam int PW   = (IW > POS_W) ? IW : POS_W;
  localparam int DW   = (AB + 1 > REQ_W) ? AB + 1 : REQ_W;
  localparam int DCW  = $clog2(DW + 1);

  typedef struct packed {
    logic [AB-1:0] start;
    logic [AB-1:0] size;
    logic [AB-1:0] requested;
    logic          taken;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic [16:0] {
    S_INIT  = 17'b00000000000000001,
    S_IDLE  = 17'b00000000000000010,
    S_CHK   = 17'b00000000000000100,
    S_RND   = 17'b00000000000001000,
    S_SCAN  = 17'b00000000000010000,
    S_PICK  = 17'b00000000000100000,
    S_SHIFT = 17'b00000000001000000,
    S_SPLIT = 17'b00000000010000000,
    S_TAKE  = 17'b00000000100000000,
    S_FREEW = 17'b00000001000000000,
    S_MRD0  = 17'b00000010000000000,
    S_MEV0  = 17'b00000100000000000,
    S_MRD   = 17'b00001000000000000,
    S_MEV   = 17'b00010000000000000,
    S_MDIV  = 17'b00100000000000000,
    S_MEND  = 17'b01000000000000000,
    S_DONE  = 17'b10000000000000000
  } state_t;

  state_t st;

  // configuration
  logic [REQ_W-1:0] total;
  logic [BLK_W-1:0] blk;
  logic             strat;
  logic [BLK_W-1:0] g;

  // table and latched request
  logic [CW-1:0]     cnt;
  logic [MODE_W-1:0] mode;
  logic [REQ_W-1:0]  req;
  logic [ADDR_W-1:0] addr;
  logic [POS_W-1:0]  pos;
  logic [NW-1:0]     need;

  // scan
  logic [CW-1:0] idx;
  logic          ev;
  logic [IW-1:0] ev_idx;
  logic          found;
  logic [IW-1:0] pick;
  entry_t        pick_e;
  logic [AB-1:0] best;

  // slot shift
  logic [IW-1:0] j;
  logic          iss;
  logic          sh_ev;
  logic [IW-1:0] sh_idx;

  // merge pass
  logic [CW-1:0] r;
  logic [IW-1:0] w;
  entry_t        prev;
  entry_t        cur;
  logic [AB:0]   sum;
  logic [AB-1:0] fs;

  // bit-serial remainder unit
  logic [DW-1:0]    div_q;
  logic [BLK_W-1:0] div_r;
  logic [DCW-1:0]   div_cnt;
  logic [BLK_W:0]   div_t;
  logic             div_done;

  // result
  logic                o_valid;
  logic [STATUS_W-1:0] res_status;
  logic [AB-1:0]       res_start;
  logic [STATUS_W-1:0] o_status;
  logic [AB-1:0]       o_start;
  logic [TOTAL_W-1:0]  o_total;

  // memory port
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;
  entry_t        rd;

  logic          fit;
  logic          match;
  logic          pair_free;
  logic [CW-1:0] r_nx;

  rafw_ram #(.WIDTH(EW), .DEPTH(MAX_REGIONS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd       = entry_t'(rdata);
  assign g        = (blk == '0) ? BLK_W'(1) : blk;
  assign div_t    = {div_r, div_q[DW-1]};
  assign div_done = (div_cnt == '0);
  assign r_nx     = r + CW'(1);

  assign fit = !rd.taken && (CMPW'(rd.size) >= CMPW'(need)) &&
               (!found || (strat && (rd.size > best)));

  always_comb begin
    match = 1'b0;
    case (mode)
      MODE_ALLOC:     match = fit;
      MODE_FREE_ADDR: match = !found && (XW'(rd.start) == XW'(addr));
      MODE_FREE_POS:  match = !found && (PW'(ev_idx) == PW'(pos));
      default:        match = 1'b0;
    endcase
  end

  assign pair_free = !prev.taken && !rd.taken;

  assign cmd.ready        = (st == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign rsp.valid        = o_valid;
  assign rsp.status       = o_status;
  assign rsp.region_start = ADDR_W'(o_start);
  assign rsp.region_total = o_total;

  // memory control: each read issues in the cycle before its data is used
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = prev;
    raddr = '0;
    case (st)
      S_INIT: begin
        we    = 1'b1;
        wdata = '{start: '0, size: AB'(total), requested: '0, taken: 1'b0};
      end
      S_SCAN: begin
        raddr = idx[IW-1:0];
      end
      S_SHIFT: begin
        raddr = j;
        if (sh_ev) begin
          we    = 1'b1;
          waddr = sh_idx + IW'(1);
          wdata = rd;
        end
      end
      S_SPLIT: begin
        we    = 1'b1;
        waddr = pick + IW'(1);
        wdata = '{start: AB'(CMPW'(pick_e.start) + CMPW'(need)),
                  size: AB'(CMPW'(pick_e.size) - CMPW'(need)),
                  requested: '0, taken: 1'b0};
      end
      S_TAKE: begin
        we    = 1'b1;
        waddr = pick;
        wdata = '{start: pick_e.start, size: AB'(need),
                  requested: AB'(req), taken: 1'b1};
      end
      S_FREEW: begin
        we    = 1'b1;
        waddr = pick;
        wdata = '{start: pick_e.start, size: pick_e.size,
                  requested: '0, taken: 1'b0};
      end
      S_MRD: begin
        raddr = r[IW-1:0];
      end
      S_MEV: begin
        we    = !pair_free;
        waddr = w;
      end
      S_MDIV: begin
        we    = div_done && (div_r != '0);
        waddr = w;
      end
      S_MEND: begin
        we    = 1'b1;
        waddr = w;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S_INIT;
      total   <= TOTAL_RESET;
      blk     <= BLOCK_RESET;
      strat   <= 1'b0;
      cnt     <= CW'(1);
      o_valid <= 1'b0;
      div_cnt <= '0;
    end else begin
      // advance the remainder unit one dividend bit per cycle
      if (!div_done) begin
        div_q   <= div_q << 1;
        div_cnt <= div_cnt - DCW'(1);
        if (div_t >= {1'b0, g}) begin
          div_r <= BLK_W'(div_t - {1'b0, g});
        end else begin
          div_r <= div_t[BLK_W-1:0];
        end
      end

      // drop a taken word; S_DONE reloads the register on its own
      if (o_valid && rsp.ready && (st != S_DONE)) begin
        o_valid <= 1'b0;
      end

      case (st)
        S_INIT: begin
          cnt <= CW'(1);
          st  <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd.valid) begin
            mode <= cmd.mode;
            req  <= cmd.req_size;
            addr <= cmd.address;
            pos  <= cmd.position;
            st   <= S_CHK;
          end
        end
        S_CHK: begin
          idx   <= '0;
          ev    <= 1'b0;
          found <= 1'b0;
          case (mode)
            MODE_ALLOC: begin
              if (req == '0 || req > total) begin
                res_status <= ST_BAD_SIZE;
                st         <= S_DONE;
              end else begin
                div_q   <= DW'(req);
                div_r   <= '0;
                div_cnt <= DCW'(DW);
                st      <= S_RND;
              end
            end
            MODE_FREE_ADDR, MODE_FREE_POS: begin
              st <= S_SCAN;
            end
            default: begin
              res_status <= ST_NOT_FOUND;
              st         <= S_DONE;
            end
          endcase
        end
        S_RND: begin
          if (div_done) begin
            // round up to the granule
            if (div_r == '0) begin
              need <= NW'(req);
            end else begin
              need <= NW'(req) + NW'(g) - NW'(div_r);
            end
            st <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx < cnt) begin
            ev     <= 1'b1;
            ev_idx <= idx[IW-1:0];
            idx    <= idx + CW'(1);
          end else begin
            ev <= 1'b0;
          end
          if (ev && match) begin
            found  <= 1'b1;
            pick   <= ev_idx;
            pick_e <= rd;
            best   <= rd.size;
          end
          if (idx >= cnt && !ev) begin
            st <= S_PICK;
          end
        end
        S_PICK: begin
          if (!found) begin
            res_status <= (mode == MODE_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
            st         <= S_DONE;
          end else if (mode != MODE_ALLOC) begin
            st <= S_FREEW;
          end else if (CMPW'(pick_e.size) > CMPW'(need)) begin
            if (cnt >= CW'(MAX_REGIONS)) begin
              res_status <= ST_FULL;
              st         <= S_DONE;
            end else begin
              j     <= IW'(cnt - CW'(1));
              iss   <= (cnt - CW'(1)) > CW'(pick);
              sh_ev <= 1'b0;
              st    <= S_SHIFT;
            end
          end else begin
            st <= S_TAKE;
          end
        end
        S_SHIFT: begin
          // move entries up by one, highest first
          if (iss) begin
            sh_ev  <= 1'b1;
            sh_idx <= j;
            if (CW'(j) == CW'(pick) + CW'(1)) begin
              iss <= 1'b0;
            end else begin
              j <= j - IW'(1);
            end
          end else begin
            sh_ev <= 1'b0;
          end
          if (!iss && !sh_ev) begin
            st <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          cnt <= cnt + CW'(1);
          st  <= S_TAKE;
        end
        S_TAKE: begin
          res_status <= ST_OK;
          res_start  <= pick_e.start;
          st         <= S_DONE;
        end
        S_FREEW: begin
          fs <= pick_e.start;
          st <= S_MRD0;
        end
        S_MRD0: begin
          st <= S_MEV0;
        end
        S_MEV0: begin
          prev <= rd;
          w    <= '0;
          r    <= CW'(1);
          st   <= (cnt == CW'(1)) ? S_MEND : S_MRD;
        end
        S_MRD: begin
          st <= S_MEV;
        end
        S_MEV: begin
          cur <= rd;
          if (pair_free) begin
            sum     <= (AB + 1)'(prev.size) + (AB + 1)'(rd.size);
            div_q   <= DW'((AB + 1)'(prev.size) + (AB + 1)'(rd.size));
            div_r   <= '0;
            div_cnt <= DCW'(DW);
            st      <= S_MDIV;
          end else begin
            // emit prev, continue from this entry
            w    <= w + IW'(1);
            prev <= rd;
            r    <= r_nx;
            st   <= (r_nx >= cnt) ? S_MEND : S_MRD;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            if (div_r == '0) begin
              prev.size <= sum[AB-1:0];
            end else begin
              w    <= w + IW'(1);
              prev <= cur;
            end
            r  <= r_nx;
            st <= (r_nx >= cnt) ? S_MEND : S_MRD;
          end
        end
        S_MEND: begin
          cnt        <= CW'(w) + CW'(1);
          res_status <= ST_OK;
          res_start  <= fs;
          st         <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!o_valid || rsp.ready) begin
            o_valid  <= 1'b1;
            o_status <= res_status;
            o_start  <= (res_status == ST_OK) ? res_start : '0;
            o_total  <= TOTAL_W'(cnt);
            st       <= S_IDLE;
          end
        end
        default: begin
          st <= S_INIT;
        end
      endcase

      // a write to a defined register rebuilds the table
      if (cfg.valid) begin
        case (cfg.index)
          REG_TOTAL_SIZE: begin
            total <= cfg.data;
            st    <= S_INIT;
          end
          REG_BLOCK_SIZE: begin
            blk <= cfg.data[BLK_W-1:0];
            st  <= S_INIT;
          end
          REG_STRATEGY: begin
            strat <= cfg.data[0];
            st    <= S_INIT;
          end
          default: begin
            strat <= strat;
          end
        endcase
      end
    end
  end

endmodule

[bench/tb.sv]
// Self-checking bench for the region allocator with first/worst fit and coalescing.
module tb import rafw_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_DEPTH = 64;
  localparam int          CYCLE_LIMIT = 8000000;
  localparam int          TAIL_CYCLES = 60;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   start;
    logic [TOTAL_W-1:0]  total;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rafw_cfg_if cfg_ch ();
  rafw_in_if  cmd_ch ();
  rafw_out_if rsp_ch ();

  region_allocator_first_worst_fit_unit dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the region table and the three registers.
  logic [ADDR_W-1:0] sh_start [TABLE_DEPTH];
  logic [ADDR_W-1:0] sh_size  [TABLE_DEPTH];
  logic [REQ_W-1:0]  sh_req   [TABLE_DEPTH];
  logic              sh_taken [TABLE_DEPTH];
  int                sh_count;
  logic [19:0]       reg_total;
  logic [BLK_W-1:0]  reg_block;
  logic              reg_worst;

  outcome_t pending_outcomes[$];
  int  failures   = 0;
  int  words_sent = 0;
  int  words_seen = 0;
  int  full_hits  = 0;
  int  merge_frees = 0;
  longint cycles  = 0;

  // Sender and receiver pacing knobs.
  bit  tx_steady = 0;
  bit  rx_steady = 0;
  int  rx_stall  = 0;
  int  rx_hold   = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               pending_outcomes.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic void rebuild_table();
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      sh_start[k] = '0;
      sh_size[k]  = '0;
      sh_req[k]   = '0;
      sh_taken[k] = 1'b0;
    end
    sh_size[0] = reg_total;
    sh_count   = 1;
  endfunction

  function automatic longint granule();
    return (reg_block == 0) ? 1 : longint'(reg_block);
  endfunction

  function automatic void release_and_merge(int k);
    longint g;
    longint sum;
    int     i;
    g = granule();
    i = 1;
    sh_taken[k] = 1'b0;
    sh_req[k]   = '0;
    while (i < sh_count) begin
      sum = longint'(sh_size[i-1]) + longint'(sh_size[i]);
      if (!sh_taken[i-1] && !sh_taken[i] && (sum % g) == 0) begin
        sh_size[i-1] = sum[ADDR_W-1:0];
        for (int j = i; j + 1 < sh_count; j++) begin
          sh_start[j] = sh_start[j+1];
          sh_size[j]  = sh_size[j+1];
          sh_req[j]   = sh_req[j+1];
          sh_taken[j] = sh_taken[j+1];
        end
        sh_count--;
        merge_frees++;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic logic [STATUS_W-1:0] place_region(logic [REQ_W-1:0] req,
                                                       output logic [ADDR_W-1:0] at);
    longint g;
    longint need;
    longint best;
    longint rest;
    int     pick;
    bit     found;
    g = granule();
    best = 0;
    pick = 0;
    found = 0;
    at = '0;
    if (req == 0 || req > reg_total) return ST_BAD_SIZE;
    need = ((longint'(req) + g - 1) / g) * g;
    for (int k = 0; k < sh_count; k++) begin
      if (sh_taken[k] || longint'(sh_size[k]) < need) continue;
      if (!reg_worst) begin
        pick = k;
        found = 1;
        break;
      end
      if (!found || longint'(sh_size[k]) > best) begin
        best = longint'(sh_size[k]);
        pick = k;
        found = 1;
      end
    end
    if (!found) return ST_NO_FIT;
    if (longint'(sh_size[pick]) > need) begin
      if (sh_count >= TABLE_DEPTH) return ST_FULL;
      for (int k = sh_count; k > pick + 1; k--) begin
        sh_start[k] = sh_start[k-1];
        sh_size[k]  = sh_size[k-1];
        sh_req[k]   = sh_req[k-1];
        sh_taken[k] = sh_taken[k-1];
      end
      rest = longint'(sh_start[pick]) + need;
      sh_start[pick+1] = rest[ADDR_W-1:0];
      rest = longint'(sh_size[pick]) - need;
      sh_size[pick+1]  = rest[ADDR_W-1:0];
      sh_req[pick+1]   = '0;
      sh_taken[pick+1] = 1'b0;
      sh_count++;
      sh_size[pick] = need[ADDR_W-1:0];
    end
    sh_taken[pick] = 1'b1;
    sh_req[pick]   = req;
    at = sh_start[pick];
    return ST_OK;
  endfunction

  function automatic outcome_t allocator_outcome(logic [MODE_W-1:0] mode,
      logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr, logic [POS_W-1:0] pos);
    outcome_t o;
    o.status = ST_NOT_FOUND;
    o.start  = '0;
    case (mode)
      MODE_ALLOC: begin
        o.status = place_region(req, o.start);
      end
      MODE_FREE_ADDR: begin
        for (int k = 0; k < sh_count; k++) begin
          if (sh_start[k] == addr) begin
            o.start  = sh_start[k];
            o.status = ST_OK;
            release_and_merge(k);
            break;
          end
        end
      end
      MODE_FREE_POS: begin
        if (int'(pos) < sh_count) begin
          o.start  = sh_start[pos];
          o.status = ST_OK;
          release_and_merge(int'(pos));
        end
      end
      default: ;
    endcase
    if (o.status != ST_OK) o.start = '0;
    if (o.status == ST_FULL) full_hits++;
    o.total = sh_count[TOTAL_W-1:0];
    return o;
  endfunction

  // Compare every response word with the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      words_seen++;
      rx_stall = rx_steady ? 0 : $urandom_range(0, 6);
      if (pending_outcomes.size() == 0) begin
        $error("response word with nothing expected");
        failures++;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          failures++;
        end
        if (rsp_ch.region_start !== want.start) begin
          $error("region_start: expected %0h, got %0h", want.start, rsp_ch.region_start);
          failures++;
        end
        if (rsp_ch.region_total !== want.total) begin
          $error("region_total: expected %0d, got %0d", want.total, rsp_ch.region_total);
          failures++;
        end
      end
    end
  end

  // Receiver: a long hold-off wins over the per-word stall.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rsp_ch.ready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        rsp_ch.ready <= 1'b0;
        rx_stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic [MODE_W-1:0] mode, logic [REQ_W-1:0] req,
                           logic [ADDR_W-1:0] addr, logic [POS_W-1:0] pos);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.mode     <= mode;
    cmd_ch.req_size <= req;
    cmd_ch.address  <= addr;
    cmd_ch.position <= pos;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_outcomes.push_back(allocator_outcome(mode, req, addr, pos));
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Write one register while the block is idle; the table restarts.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_TOTAL_SIZE: reg_total = value[19:0];
      REG_BLOCK_SIZE: reg_block = value[BLK_W-1:0];
      REG_STRATEGY:   reg_worst = value[0];
      default: ;
    endcase
    rebuild_table();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_layout(logic [19:0] total, logic [CFG_DATA_W-1:0] blk, bit worst);
    write_reg(REG_TOTAL_SIZE, total);
    write_reg(REG_BLOCK_SIZE, blk);
    write_reg(REG_STRATEGY, {19'h7FFFF, worst});
  endtask

  // Well-formed traffic: mostly allocations and frees of live regions, some noise.
  task automatic random_word();
    int   pick;
    int   taken_idx[$];
    logic [REQ_W-1:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      if ($urandom_range(0, 9) == 0) req = REQ_W'($urandom_range(1, reg_total + 1));
      else req = REQ_W'($urandom_range(1, (reg_total >> $urandom_range(2, 7)) + 1));
      send_word(MODE_ALLOC, req, ADDR_W'($urandom), POS_W'($urandom));
    end else if (pick < 85) begin
      for (int k = 0; k < sh_count; k++) if (sh_taken[k]) taken_idx.push_back(k);
      if (taken_idx.size() == 0)
        send_word(MODE_FREE_ADDR, REQ_W'($urandom), sh_start[0], POS_W'($urandom));
      else
        send_word(MODE_FREE_ADDR, REQ_W'($urandom),
                  sh_start[taken_idx[$urandom_range(0, taken_idx.size() - 1)]],
                  POS_W'($urandom));
    end else if (pick < 95) begin
      send_word(MODE_FREE_POS, REQ_W'($urandom), ADDR_W'($urandom),
                POS_W'($urandom_range(0, (sh_count + 1 > 63) ? 63 : sh_count + 1)));
    end else begin
      // Noise: any field value, unused mode included.
      send_word(MODE_W'($urandom), REQ_W'($urandom), ADDR_W'($urandom),
                POS_W'($urandom));
    end
  endtask

  task automatic test_directed();
    send_word(MODE_ALLOC, '0, '0, '0);                  // zero request
    send_word(MODE_ALLOC, 20'hFFFFF, 20'hFFFFF, 6'h3F); // over total
    send_word(MODE_ALLOC, 20'd65537, '0, '0);
    send_word(MODE_ALLOC, 20'd1, '0, '0);               // rounds to one granule
    send_word(MODE_ALLOC, 20'd65536, '0, '0);           // no fit left
    send_word(MODE_ALLOC, 20'd100, '0, '0);
    send_word(MODE_FREE_ADDR, '0, 20'd5, '0);           // address not found
    send_word(MODE_FREE_ADDR, '0, 20'hFFFFF, '0);
    send_word(MODE_FREE_POS, '0, '0, 6'd63);            // position out of range
    send_word(MODE_FREE_POS, '0, '0, 6'd2);             // already free, merge runs
    send_word(MODE_UNUSED, 20'd16, '0, '0);             // unused mode
    send_word(MODE_FREE_ADDR, '0, 20'd0, '0);           // frees entry zero, taken neighbor blocks a merge
    send_word(MODE_FREE_POS, '0, '0, 6'd0);
    send_word(MODE_ALLOC, 20'd65536, '0, '0);           // whole memory, no fit while a region is live
    send_word(MODE_FREE_POS, '0, '0, 6'd0);
    // Zero and one byte totals, then worst fit with exact fits.
    set_layout(20'd0, 20'd16, 1'b0);
    send_word(MODE_ALLOC, 20'd1, '0, '0);
    send_word(MODE_FREE_POS, '0, '0, 6'd0);
    set_layout(20'd1, 20'd0, 1'b1);
    send_word(MODE_ALLOC, 20'd1, '0, '0);
    send_word(MODE_ALLOC, 20'd1, '0, '0);
    send_word(MODE_FREE_ADDR, '0, 20'd0, '0);
    set_layout(20'd256, 20'd64, 1'b1);
    send_word(MODE_ALLOC, 20'd64, '0, '0);
    send_word(MODE_ALLOC, 20'd65, '0, '0);
    send_word(MODE_ALLOC, 20'd64, '0, '0);
    send_word(MODE_FREE_ADDR, '0, 20'd64, '0);
    drain();
  endtask

  task automatic test_table_full();
    set_layout(20'hFFFFF, 20'd1, 1'b0);
    for (int n = 0; n < 70; n++)
      send_word(MODE_ALLOC, REQ_W'($urandom_range(1, 3)), '0, '0);
    for (int n = 0; n < 20; n++)
      send_word(MODE_FREE_POS, '0, '0, POS_W'($urandom_range(0, sh_count - 1)));
    drain();
  endtask

  task automatic test_random_phase(logic [19:0] total, logic [CFG_DATA_W-1:0] blk,
                                   bit worst, int words);
    set_layout(total, blk, worst);
    for (int n = 0; n < words; n++) random_word();
    drain();
  endtask

  task automatic test_back_to_back();
    tx_steady = 1;
    rx_steady = 1;
    test_random_phase(20'd4096, 20'd8, 1'b1, 80);
    tx_steady = 0;
    rx_steady = 0;
  endtask

  // Hold the response side while words keep coming, then pause until all return.
  task automatic test_output_hold();
    set_layout(20'd65536, 20'd16, 1'b0);
    rx_hold = 3000;
    for (int n = 0; n < 25; n++) random_word();
    drain();
    for (int n = 0; n < 25; n++) random_word();
    drain();
  endtask

  initial begin
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.mode     = MODE_ALLOC;
    cmd_ch.req_size = '0;
    cmd_ch.address  = '0;
    cmd_ch.position = '0;
    reg_total = TOTAL_RESET;
    reg_block = BLOCK_RESET;
    reg_worst = 1'b0;
    rebuild_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_table_full();
    test_back_to_back();
    test_output_hold();
    test_random_phase(20'd65536, 20'd16, 1'b0, 170);
    test_random_phase(20'd65536, 20'd16, 1'b1, 170);
    test_random_phase(20'hFFFFF, 20'd65536, 1'b1, 90);
    test_random_phase(20'hFFFFF, 20'hFFFFF, 1'b0, 60);
    test_random_phase(20'd1000, 20'd0, 1'b1, 120);
    test_random_phase(20'd777, 20'd24, 1'b0, 120);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d request words and %0d responses over register sweeps,",
             words_sent, words_seen);
    $display("with %0d table-full rejections and %0d coalesced pairs", full_hits,
             merge_frees);
    if (failures == 0 && pending_outcomes.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
src/rafw_pkg.sv
src/rafw_if.sv
src/rafw_ram.sv
src/region_allocator_first_worst_fit_unit.sv
bench/tb.sv
